FILE: sv/cpk_pkg.sv
// ----------------------------------------------------------------------------
// cpk_pkg
// Types, constants and codes shared by the process capability block.
// ----------------------------------------------------------------------------
`default_nettype none
package cpk_pkg;

  localparam int CPK_MAX_SAMPLES = 1024;
  // widest count and sum over the whole range of the sample limit
  localparam int CPK_CNT_W = 17;
  localparam int CPK_SUM_W = 24 + CPK_CNT_W;
  localparam logic [23:0] CPK_QMAX = 24'h7FFFFF;
  localparam logic [23:0] CPK_QMIN = 24'h800000;

  localparam logic [1:0] CFG_NOMINAL = 2'd0;
  localparam logic [1:0] CFG_UPPER   = 2'd1;
  localparam logic [1:0] CFG_LOWER   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FEW     = 2'd1;
  localparam logic [1:0] ST_NO_SPRD = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  typedef struct packed {
    logic signed [23:0] sample;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [23:0] mean_value;
    logic [22:0]        std_dev;
    logic signed [23:0] cpk_upper;
    logic signed [23:0] cpk_lower;
    logic signed [23:0] cp_value;
    logic [10:0]        outside_count;
    logic [10:0]        sample_count;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic signed [23:0] nominal;
    logic signed [23:0] upper_tol;
    logic signed [23:0] lower_tol;
  } cfg_regs_t;

  // one closed set handed from front to back
  typedef struct packed {
    logic signed [CPK_SUM_W-1:0] sum;
    logic [CPK_CNT_W-1:0]        cnt;
    logic [CPK_CNT_W-1:0]        tally;
    logic                        dropped;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MEAN, B_PASS, B_VAR, B_SQRT, B_DIVU, B_DIVL, B_DIVP, B_OUT
  } back_state_t;

endpackage
`default_nettype wire

FILE: sv/cpk_ram.sv
// ----------------------------------------------------------------------------
// cpk_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module cpk_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/cpk_div.sv
// ----------------------------------------------------------------------------
// cpk_div
// Unsigned restoring divider, 64 by 64 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cpk_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic      [63:0] quo
);
  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r, quo_r, den_r;
  logic [64:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem_r, quo_r[63]};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? 64'(trial - {1'b0, den_r}) : trial[63:0];
      quo_r <= {quo_r[62:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

FILE: sv/cpk_front.sv
// ----------------------------------------------------------------------------
// cpk_front
// Stores samples, keeps the running sum, count and out-of-limit tally.
// ----------------------------------------------------------------------------
`default_nettype none
module cpk_front #(
  parameter int MAX_SAMPLES = 1024,
  parameter int AW          = $clog2(MAX_SAMPLES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire cpk_pkg::in_t      in_data,
  input  wire cpk_pkg::cfg_regs_t cfg,
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output logic                   push,
  output cpk_pkg::job_t          job
);
  import cpk_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = 24 + CW;

  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt, tally_r, tally_nxt;
  logic                 drop_r, drop_nxt, full, outside;
  logic signed [24:0]   up_s, lo_s, x_s;

  always_comb begin
    up_s    = {cfg.nominal[23], cfg.nominal} + {cfg.upper_tol[23], cfg.upper_tol};
    lo_s    = {cfg.nominal[23], cfg.nominal} + {cfg.lower_tol[23], cfg.lower_tol};
    x_s     = {in_data.sample[23], in_data.sample};
    outside = (x_s > up_s) || (x_s < lo_s);
    full    = cnt_r == CW'(MAX_SAMPLES);
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    tally_nxt = tally_r;
    drop_nxt  = drop_r;
    if (accept) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        sum_nxt   = sum_r + SW'(in_data.sample);
        cnt_nxt   = cnt_r + CW'(1);
        tally_nxt = tally_r + CW'(outside);
      end
    end
    ram_we       = accept && !full;
    ram_waddr    = cnt_r[AW-1:0];
    push         = accept && in_data.last;
    job.sum      = CPK_SUM_W'(sum_nxt);
    job.cnt      = CPK_CNT_W'(cnt_nxt);
    job.tally    = CPK_CNT_W'(tally_nxt);
    job.dropped  = drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      sum_r   <= '0;
      cnt_r   <= '0;
      tally_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      tally_r <= tally_nxt;
      drop_r  <= drop_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: sv/cpk_queue.sv
// ----------------------------------------------------------------------------
// cpk_queue
// Two-entry queue of closed sets between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module cpk_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire cpk_pkg::job_t din,
  input  wire logic          pop,
  output cpk_pkg::job_t      dout,
  output logic               empty
);
  import cpk_pkg::*;

  job_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= '0;
    end else begin
      if (push && fill_r != 2'd2) begin
        wp_r <= !wp_r;
      end
      if (pop && !empty) begin
        rp_r <= !rp_r;
      end
      fill_r <= fill_r + 2'(push && fill_r != 2'd2) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && fill_r != 2'd2) begin
      slot_r[wp_r] <= din;
    end
  end

  assign dout  = slot_r[rp_r];
  assign empty = fill_r == 2'd0;
endmodule
`default_nettype wire

FILE: sv/cpk_back.sv
// ----------------------------------------------------------------------------
// cpk_back
// Mean, squared deviation pass, square root and capability indices.
// ----------------------------------------------------------------------------
`default_nettype none
module cpk_back #(
  parameter int AW = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cpk_pkg::cfg_regs_t cfg,
  input  wire logic               q_empty,
  input  wire cpk_pkg::job_t      q_dout,
  output logic                    q_pop,
  output logic [AW-1:0]           ram_raddr,
  input  wire logic [23:0]        ram_rdata,
  output logic                    out_valid,
  output cpk_pkg::out_t           out_data,
  output logic                    busy
);
  import cpk_pkg::*;

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic signed [23:0] mean_r, cpku_r, cpkl_r, cp_r;
  logic [22:0] sd_r;
  logic [1:0]  status_r;
  logic [63:0] acc_r, sqv_r, sqres_r, sqbit_r;
  logic [CPK_CNT_W-1:0] rd_cnt_r;
  logic        v1_r, v2_r, issued_r, out_valid_r;
  logic [48:0] sq_r;
  out_t        out_r;

  logic        div_start, div_done, neg_s, pass_rd, pass_end;
  logic [63:0] div_num, div_den, div_quo, sq_try, den3;
  logic signed [24:0] up_s, lo_s, rng_s, d_s;
  logic signed [25:0] du_s, dl_s;
  logic [25:0] mag_u, mag_l;
  logic [CPK_SUM_W-1:0] sum_mag;
  logic [64:0] acc_sum;
  logic [22:0] sd_sat;
  logic [49:0] sq_full;

  function automatic logic [23:0] sat_q(input logic [63:0] q, input logic neg);
    if (neg) begin
      return (q > 64'h800000) ? CPK_QMIN : -q[23:0];
    end
    return (q > 64'(CPK_QMAX)) ? CPK_QMAX : q[23:0];
  endfunction

  cpk_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    up_s    = {cfg.nominal[23], cfg.nominal} + {cfg.upper_tol[23], cfg.upper_tol};
    lo_s    = {cfg.nominal[23], cfg.nominal} + {cfg.lower_tol[23], cfg.lower_tol};
    rng_s   = {cfg.upper_tol[23], cfg.upper_tol} - {cfg.lower_tol[23], cfg.lower_tol};
    du_s    = {up_s[24], up_s} - {{2{mean_r[23]}}, mean_r};
    dl_s    = {{2{mean_r[23]}}, mean_r} - {lo_s[24], lo_s};
    mag_u   = du_s[25] ? 26'(-du_s) : 26'(du_s);
    mag_l   = dl_s[25] ? 26'(-dl_s) : 26'(dl_s);
    sum_mag = job_r.sum[CPK_SUM_W-1] ? CPK_SUM_W'(-job_r.sum) : CPK_SUM_W'(job_r.sum);
    den3    = 64'({sd_r, 1'b0}) + 64'(sd_r);
    div_num = '0;
    div_den = 64'd1;
    neg_s   = 1'b0;
    case (state_r)
      B_MEAN: begin
        div_num = 64'(sum_mag);
        div_den = 64'(job_r.cnt);
        neg_s   = job_r.sum[CPK_SUM_W-1];
      end
      B_VAR: begin
        div_num = acc_r;
        div_den = 64'(job_r.cnt - CPK_CNT_W'(1));
      end
      B_DIVU: begin
        div_num = 64'(mag_u) << 12;
        div_den = den3;
        neg_s   = du_s[25];
      end
      B_DIVL: begin
        div_num = 64'(mag_l) << 12;
        div_den = den3;
        neg_s   = dl_s[25];
      end
      B_DIVP: begin
        div_num = rng_s[24] ? 64'(-rng_s) << 12 : 64'(rng_s) << 12;
        div_den = den3 << 1;
        neg_s   = rng_s[24];
      end
      default: ;
    endcase
    div_start = !issued_r && (state_r == B_MEAN || state_r == B_VAR ||
                state_r == B_DIVU || state_r == B_DIVL || state_r == B_DIVP);
    pass_rd   = state_r == B_PASS && rd_cnt_r != job_r.cnt;
    pass_end  = state_r == B_PASS && rd_cnt_r == job_r.cnt && !v1_r && !v2_r;
    ram_raddr = rd_cnt_r[AW-1:0];
    d_s       = {ram_rdata[23], ram_rdata} - {mean_r[23], mean_r};
    sq_full   = 50'(d_s * d_s);
    acc_sum   = {1'b0, acc_r} + 65'(sq_r);
    sq_try    = sqres_r + sqbit_r;
    sd_sat    = (sqres_r > 64'(CPK_QMAX)) ? CPK_QMAX[22:0] : sqres_r[22:0];
    q_pop     = state_r == B_IDLE && !q_empty;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_MEAN;
      B_MEAN: if (div_done) state_nxt = (job_r.cnt < CPK_CNT_W'(2)) ? B_OUT : B_PASS;
      B_PASS: if (pass_end) state_nxt = B_VAR;
      B_VAR:  if (div_done) state_nxt = B_SQRT;
      B_SQRT: if (sqbit_r == '0) state_nxt = (sd_sat == '0) ? B_OUT : B_DIVU;
      B_DIVU: if (div_done) state_nxt = B_DIVL;
      B_DIVL: if (div_done) state_nxt = B_DIVP;
      B_DIVP: if (div_done) state_nxt = B_OUT;
      B_OUT:  state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      issued_r    <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == B_OUT;
      v1_r        <= pass_rd;
      v2_r        <= v1_r;
      if (div_start) begin
        issued_r <= 1'b1;
      end else if (div_done) begin
        issued_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        job_r    <= q_dout;
        sd_r     <= '0;
        cpku_r   <= '0;
        cpkl_r   <= '0;
        cp_r     <= '0;
        acc_r    <= '0;
        rd_cnt_r <= '0;
        status_r <= ST_FEW;
      end
      B_MEAN: if (div_done) mean_r <= sat_q(div_quo, neg_s);
      B_PASS: begin
        if (pass_rd) rd_cnt_r <= rd_cnt_r + CPK_CNT_W'(1);
        if (v1_r) sq_r <= sq_full[48:0];
        // saturate the sum of squares rather than wrap
        if (v2_r) acc_r <= acc_sum[64] ? '1 : acc_sum[63:0];
      end
      B_VAR: if (div_done) begin
        sqv_r   <= div_quo;
        sqres_r <= '0;
        sqbit_r <= 64'd1 << 62;
      end
      B_SQRT: begin
        if (sqbit_r != '0) begin
          if (sqv_r >= sq_try) begin
            sqv_r   <= sqv_r - sq_try;
            sqres_r <= (sqres_r >> 1) + sqbit_r;
          end else begin
            sqres_r <= sqres_r >> 1;
          end
          sqbit_r <= sqbit_r >> 2;
        end else begin
          sd_r     <= sd_sat;
          status_r <= job_r.dropped ? ST_DROPPED : ((sd_sat == '0) ? ST_NO_SPRD : ST_OK);
        end
      end
      B_DIVU: if (div_done) cpku_r <= sat_q(div_quo, neg_s);
      B_DIVL: if (div_done) cpkl_r <= sat_q(div_quo, neg_s);
      B_DIVP: if (div_done) cp_r <= sat_q(div_quo, neg_s);
      B_OUT: begin
        out_r.mean_value    <= mean_r;
        out_r.std_dev       <= sd_r;
        out_r.cpk_upper     <= cpku_r;
        out_r.cpk_lower     <= cpkl_r;
        out_r.cp_value      <= cp_r;
        out_r.outside_count <= job_r.tally[10:0];
        out_r.sample_count  <= job_r.cnt[10:0];
        out_r.status        <= status_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign busy      = state_r != B_IDLE;
endmodule
`default_nettype wire

FILE: sv/process_capability_cpk.sv
// ----------------------------------------------------------------------------
// process_capability_cpk
// Sample store with Cp / Cpk computation over each closed set.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in_     | start, busy          | in_data  (sample, last)
//  out_    | out_valid strobe     | out_data (mean .. status)
//  cfg_    | cfg_valid, cfg_ready | cfg_index, cfg_data
//
//  Samples load one per cycle into the sample RAM while busy is low.
//  A sample with last set raises busy while its set is worked through:
//  five serial divisions, one RAM read per stored sample and a 32-step
//  square root; zero spread skips the three index divisions.
//  The result strobe lasts one cycle.
//  Reset is synchronous; the sample RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module process_capability_cpk #(
  parameter int MAX_SAMPLES = cpk_pkg::CPK_MAX_SAMPLES
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire cpk_pkg::in_t   in_data,
  output logic                out_valid,
  output cpk_pkg::out_t       out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [23:0]    cfg_data
);
  import cpk_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);

  cfg_regs_t   cfg_r;
  logic        accept, ram_we, push, q_empty, q_pop, back_busy;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [23:0] ram_rdata;
  job_t        job, q_dout;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = !q_empty || back_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NOMINAL: cfg_r.nominal   <= cfg_data;
        CFG_UPPER:   cfg_r.upper_tol <= cfg_data;
        CFG_LOWER:   cfg_r.lower_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  cpk_front #(.MAX_SAMPLES(MAX_SAMPLES), .AW(AW)) u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .in_data(in_data), .cfg(cfg_r),
    .ram_we(ram_we), .ram_waddr(ram_waddr), .push(push), .job(job)
  );

  cpk_ram #(.WIDTH(24), .DEPTH(MAX_SAMPLES), .AW(AW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_data.sample),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  cpk_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .din(job), .pop(q_pop),
    .dout(q_dout), .empty(q_empty)
  );

  cpk_back #(.AW(AW)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_empty(q_empty), .q_dout(q_dout),
    .q_pop(q_pop), .ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
    .out_valid(out_valid), .out_data(out_data), .busy(back_busy)
  );
endmodule
`default_nettype wire

FILE: sv/cpk_checker.sv
// ----------------------------------------------------------------------------
// cpk_checker
// Port-level checks of the process capability block.
// ----------------------------------------------------------------------------
`default_nettype none
module cpk_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire cpk_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire cpk_pkg::out_t out_data
);
  import cpk_pkg::*;

  // a closing beat must hold off the next sample
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.last |=> busy) else $error("busy not raised");

  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe too long");

  a_ok_spread: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK |-> out_data.std_dev != '0)
    else $error("ok status with zero spread");

  a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FEW |-> out_data.std_dev == '0 &&
    out_data.cpk_upper == '0 && out_data.cpk_lower == '0 && out_data.cp_value == '0)
    else $error("indices set with fewer than two samples");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid) else $error("activity after reset");
endmodule

bind process_capability_cpk cpk_checker u_cpk_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
  .out_valid(out_valid), .out_data(out_data)
);
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives sample sets and register settings into process_capability_cpk and
// checks every result beat against a cycle-free capability calculator.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cpk_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 1400;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  process_capability_cpk u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // calculator state
  int      nominal_q, upper_q, lower_q;
  int      set_samples[$];
  longint  set_sum;
  int      set_outside;
  bit      set_dropped;
  out_t    pending_results[$];

  int sets_closed, samples_sent, results_seen, mismatches, idle_cycles;
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp_q(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // fold one accepted sample into the open set; close it when last is set
  function automatic void capability_step(in_t it);
    longint x, up_lim, lo_lim, mean, sd_s, d;
    longint unsigned sq_sum, sq, sd;
    out_t r;
    x = longint'($signed(it.sample));
    up_lim = longint'(nominal_q) + upper_q;
    lo_lim = longint'(nominal_q) + lower_q;
    if (set_samples.size() < CPK_MAX_SAMPLES) begin
      set_samples.push_back(int'(x));
      set_sum += x;
      if (x > up_lim || x < lo_lim) set_outside++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!it.last) return;
    r = '0;
    mean = 0;
    sd = 0;
    if (set_samples.size() > 0) mean = set_sum / longint'(set_samples.size());
    r.mean_value = mean[23:0];
    if (set_samples.size() < 2) begin
      r.status = ST_FEW;
    end else begin
      sq_sum = 0;
      foreach (set_samples[i]) begin
        d = longint'(set_samples[i]) - mean;
        if (d < 0) d = -d;
        sq = longint'(d) * longint'(d);
        sq_sum += sq;
      end
      sd = int_sqrt(sq_sum / longint'(set_samples.size() - 1));
      if (sd > 8388607) sd = 8388607;
      if (sd != 0) begin
        sd_s = longint'(sd);
        r.cpk_upper = 24'(clamp_q((up_lim - mean) * 4096 / (3 * sd_s)));
        r.cpk_lower = 24'(clamp_q((mean - lo_lim) * 4096 / (3 * sd_s)));
        r.cp_value  = 24'(clamp_q((longint'(upper_q) - lower_q) * 4096 / (6 * sd_s)));
      end
      if (set_dropped) r.status = ST_DROPPED;
      else if (sd == 0) r.status = ST_NO_SPRD;
      else r.status = ST_OK;
    end
    r.std_dev = sd[22:0];
    r.outside_count = 11'(set_outside);
    r.sample_count = 11'(set_samples.size());
    pending_results.push_back(r);
    set_samples.delete();
    set_sum = 0;
    set_outside = 0;
    set_dropped = 1'b0;
    sets_closed++;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.mean_value !== want.mean_value || out_data.std_dev !== want.std_dev ||
            out_data.cpk_upper !== want.cpk_upper || out_data.cpk_lower !== want.cpk_lower ||
            out_data.cp_value !== want.cp_value ||
            out_data.outside_count !== want.outside_count ||
            out_data.sample_count !== want.sample_count || out_data.status !== want.status)
        begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %p", want);
            $display("  actual   %p", out_data);
          end
        end
      end
    end
  end

  // watchdog: cycles with no handshake of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // drive one sample beat and hold it until accepted; start stays high
  task automatic send_sample(input logic signed [23:0] s, input bit lst);
    in_t it;
    it.sample = s;
    it.last = lst;
    @(negedge clk);
    start = 1'b1;
    in_data = it;
    do @(posedge clk); while (busy);
    capability_step(it);
    samples_sent++;
  endtask

  task automatic idle_gap(input int cycles);
    @(negedge clk);
    start = 1'b0;
    in_data = '0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results;
    idle_gap(0);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = 24'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NOMINAL: nominal_q = int'($signed(24'(val)));
      CFG_UPPER:   upper_q   = int'($signed(24'(val)));
      CFG_LOWER:   lower_q   = int'($signed(24'(val)));
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_limits(input int nom, input int up_t, input int lo_t);
    drain_results();
    write_reg(CFG_NOMINAL, nom);
    write_reg(CFG_UPPER, up_t);
    write_reg(CFG_LOWER, lo_t);
  endtask

  function automatic logic signed [23:0] pick_sample(input int spread);
    int v;
    if ($urandom_range(0, 9) == 0) return 24'($urandom);
    v = nominal_q + $signed($urandom_range(0, 2 * spread)) - spread;
    return 24'(v);
  endfunction

  task automatic test_corner_sets;
    set_limits(0, 4096, -4096);
    send_sample(24'sh001000, 1'b1);                      // lone sample
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh800000, 1'b1);                     // widest spread
    send_sample(24'sh000123, 1'b0);
    send_sample(24'sh000123, 1'b0);
    send_sample(24'sh000123, 1'b1);                      // no spread
    send_sample(24'sh000000, 1'b0);
    send_sample(24'sh000001, 1'b1);                      // tiny spread, large indices
    set_limits(8388607, 8388607, -8388608);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh800000, 1'b0);
    send_sample(24'sh000000, 1'b1);
    set_limits(-8388608, -8388608, 8388607);              // inverted limits
    send_sample(24'sh000010, 1'b0);
    send_sample(-24'sh000010, 1'b0);
    send_sample(24'sh400000, 1'b1);
  endtask

  task automatic test_store_full;
    set_limits(0, 2048, -2048);
    // fill the store and drop two further beats, the last one closing the set
    for (int i = 0; i < CPK_MAX_SAMPLES + 2; i++)
      send_sample(pick_sample(4096), i == CPK_MAX_SAMPLES + 1);
  endtask

  task automatic test_random_sets(input int budget);
    int sent, burst, set_len, spread;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 5) == 0)
        set_limits($urandom_range(0, 40000) - 20000, $urandom_range(0, 20000),
                   -$signed($urandom_range(0, 20000)));
      spread = (1 << $urandom_range(0, 14));
      set_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
      burst = $urandom_range(1, 12);
      for (int i = 0; i < set_len; i++) begin
        send_sample(pick_sample(spread), i == set_len - 1);
        sent++;
        if (--burst == 0) begin
          if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
          burst = $urandom_range(1, 12);
        end
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NOMINAL;
    cfg_data = '0;
    nominal_q = 0;
    upper_q = 0;
    lower_q = 0;
    set_sum = 0;
    set_outside = 0;
    set_dropped = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    send_sample(24'sh000100, 1'b0);                      // reset limits, all zero
    send_sample(-24'sh000100, 1'b1);
    test_corner_sets();
    test_store_full();
    set_limits(0, 8192, -8192);
    test_random_sets(560);
    set_limits(8388607, -8388608, 8388607);
    test_random_sets(40);

    drain_results();
    $display("covered %0d samples in %0d sets, %0d results checked, %0d mismatches",
             samples_sent, sets_closed, results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
